// ===== design/arip_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII radix integer parser package
// Shared types, constants and character classification helpers.
// ----------------------------------------------------------------------------
package arip_pkg;

    localparam int unsigned CHAR_W          = 8;
    localparam int unsigned RADIX_W         = 6;
    localparam int unsigned DIGIT_W         = 6;
    localparam int unsigned OUT_W           = 32;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_BIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    // bases at or above these take 'b' / 'x' as plain digits
    localparam logic [RADIX_W-1:0] RADIX_B_DIGIT = 6'd12;
    localparam logic [RADIX_W-1:0] RADIX_X_DIGIT = 6'd34;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SPACE,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_DIGIT = 3'd1,
        ST_SIGN      = 3'd2,
        ST_PREFIX    = 3'd3,
        ST_BAD_BASE  = 3'd4
    } t_status;

    typedef struct packed {
        t_phase  phase;
        logic    negative;
        logic    emit;
        t_status status;
    } t_step_ctl;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_num(input logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return c >= CH_LA && c <= CH_LZ;
    endfunction

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return c >= CH_UA && c <= CH_UZ;
    endfunction

    // only meaningful for alphanumeric bytes
    function automatic logic [DIGIT_W-1:0] digit_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        if (is_num(c)) begin
            d = c - CH_ZERO;
        end else if (is_lower(c)) begin
            d = c - CH_LA + 8'd10;
        end else begin
            d = c - CH_UA + 8'd10;
        end
        return d[DIGIT_W-1:0];
    endfunction

endpackage

// ===== design/arip_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Radix configuration channel
// Single-register write channel with valid/ready.
// ----------------------------------------------------------------------------
interface arip_cfg_if
    import arip_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

// ===== design/arip_char_if.sv =====
// ----------------------------------------------------------------------------
// Character input channel
// One ASCII byte per transfer plus a start-of-string flag.
// ----------------------------------------------------------------------------
interface arip_char_if
    import arip_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              start_of_string;

    modport source (output valid, output character, output start_of_string, input ready);
    modport sink   (input valid, input character, input start_of_string, output ready);
endinterface

// ===== design/arip_res_if.sv =====
// ----------------------------------------------------------------------------
// Parse result channel
// Parsed value and status code, one transfer per string.
// ----------------------------------------------------------------------------
interface arip_res_if
    import arip_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] value;
    t_status                 status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== design/arip_step.sv =====
// ----------------------------------------------------------------------------
// Parser step logic
// Next parse state, accumulator update and result for one character.
// ----------------------------------------------------------------------------
module arip_step
    import arip_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic [CHAR_W-1:0]      i_char,
    input  logic                   i_sos,
    input  logic [RADIX_W-1:0]     i_radix,
    input  t_phase                 i_phase,
    input  logic                   i_negative,
    input  logic [VALUE_WIDTH-1:0] i_acc,
    output t_step_ctl              o_ctl,
    output logic [VALUE_WIDTH-1:0] o_acc,
    output logic [OUT_W-1:0]       o_value
);

    t_phase                 ph;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] acc;
    logic                   alnum;
    logic [DIGIT_W-1:0]     dval;
    logic [VALUE_WIDTH-1:0] mac;
    logic                   bad_base;

    // digit step outcome
    logic                   ds_emit;
    t_status                ds_status;
    logic [VALUE_WIDTH-1:0] ds_res;

    logic [VALUE_WIDTH-1:0] res;
    logic signed [63:0]     res_ext;

    always_comb begin
        ph   = i_sos ? PH_SPACE : i_phase;
        neg  = i_sos ? 1'b0 : i_negative;
        acc  = i_sos ? '0 : i_acc;

        alnum = is_num(i_char) || is_lower(i_char) || is_upper(i_char);
        dval  = digit_val(i_char);
        mac   = VALUE_WIDTH'(acc * VALUE_WIDTH'(i_radix)) + VALUE_WIDTH'(dval);
        bad_base = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);

        ds_emit   = 1'b1;
        ds_status = ST_OK;
        ds_res    = acc;
        if (!alnum) begin
            if (i_radix == RADIX_DEC && neg) begin
                ds_res = '0 - acc;
            end
        end else if ({2'b00, dval} >= {2'b00, i_radix}) begin
            ds_status = ST_BAD_DIGIT;
        end else begin
            ds_emit = 1'b0;
        end

        o_ctl.phase    = ph;
        o_ctl.negative = neg;
        o_ctl.emit     = 1'b0;
        o_ctl.status   = ST_OK;
        o_acc          = acc;
        res            = '0;

        if (ph != PH_IDLE) begin
            if (bad_base) begin
                o_ctl.emit   = 1'b1;
                o_ctl.status = ST_BAD_BASE;
                res          = VALUE_WIDTH'(i_radix);
            end else begin
                // take the digit path unless a special case below claims the byte
                logic use_digit;
                use_digit = 1'b0;
                case (ph)
                    PH_SPACE: begin
                        if (is_space(i_char)) begin
                            use_digit = 1'b0;
                        end else if (i_char == CH_PLUS || i_char == CH_MINUS) begin
                            if (i_radix != RADIX_DEC) begin
                                o_ctl.emit   = 1'b1;
                                o_ctl.status = ST_SIGN;
                            end else begin
                                o_ctl.negative = (i_char == CH_MINUS);
                                o_ctl.phase    = PH_DIGITS;
                            end
                        end else if (i_char == CH_ZERO) begin
                            o_ctl.phase = PH_ZERO;
                        end else begin
                            use_digit = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (i_char == CH_LB || i_char == CH_UB) begin
                            if (i_radix == RADIX_BIN) begin
                                o_ctl.phase = PH_DIGITS;
                            end else if (i_radix < RADIX_B_DIGIT) begin
                                o_ctl.emit   = 1'b1;
                                o_ctl.status = ST_PREFIX;
                            end else begin
                                use_digit = 1'b1;
                            end
                        end else if (i_char == CH_LX || i_char == CH_UX) begin
                            if (i_radix == RADIX_HEX) begin
                                o_ctl.phase = PH_DIGITS;
                            end else if (i_radix < RADIX_X_DIGIT) begin
                                o_ctl.emit   = 1'b1;
                                o_ctl.status = ST_PREFIX;
                            end else begin
                                use_digit = 1'b1;
                            end
                        end else begin
                            use_digit = 1'b1;
                        end
                    end
                    default: begin
                        use_digit = 1'b1;
                    end
                endcase
                if (use_digit) begin
                    if (ds_emit) begin
                        o_ctl.emit   = 1'b1;
                        o_ctl.status = ds_status;
                        res          = ds_res;
                    end else begin
                        o_acc       = mac;
                        o_ctl.phase = PH_DIGITS;
                    end
                end
            end
            if (o_ctl.emit) begin
                o_ctl.phase = PH_IDLE;
            end
        end

        res_ext = 64'(signed'(res));
        o_value = res_ext[OUT_W-1:0];
    end

endmodule

// ===== design/ascii_radix_integer_parser.sv =====
// ----------------------------------------------------------------------------
// ASCII radix integer parser
// Parses a character stream into an integer in base 2 to 36.
// ----------------------------------------------------------------------------
// Pipeline: the character that ends the parse passes the input register and the
//   step stage (one multiply-add), then the result register, to reach o_res.
// Throughput: one character per cycle while o_res does not hold back a result.
// Reset (i_rst_n low, synchronous): radix returns to 10, the parser goes idle
//   and both pipeline registers are emptied.
module ascii_radix_integer_parser
    import arip_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arip_cfg_if.sink    i_cfg,
    arip_char_if.sink   i_char,
    arip_res_if.source  o_res
);

    logic [RADIX_W-1:0]     r_radix;
    logic                   r_in_valid;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_sos;
    t_phase                 r_phase;
    logic                   r_negative;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_value;
    t_status                r_status;

    t_step_ctl              step_ctl;
    logic [VALUE_WIDTH-1:0] n_acc;
    logic [OUT_W-1:0]       n_value;
    logic                   advance;
    logic                   step_fire;

    // step stage may run when the result register is free or being drained
    assign advance   = !r_out_valid || o_res.ready;
    assign step_fire = r_in_valid && advance;

    assign i_cfg.ready  = 1'b1;
    assign i_char.ready = !r_in_valid || advance;

    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_value;
    assign o_res.status = r_status;

    arip_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .i_char     (r_char),
        .i_sos      (r_sos),
        .i_radix    (r_radix),
        .i_phase    (r_phase),
        .i_negative (r_negative),
        .i_acc      (r_acc),
        .o_ctl      (step_ctl),
        .o_acc      (n_acc),
        .o_value    (n_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_RESET;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_negative  <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_radix <= i_cfg.radix;
            end
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (step_fire) begin
                r_phase    <= step_ctl.phase;
                r_negative <= step_ctl.negative;
                r_acc      <= n_acc;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && step_ctl.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.character;
            r_sos  <= i_char.start_of_string;
        end
        if (step_fire && step_ctl.emit) begin
            r_value  <= n_value;
            r_status <= step_ctl.status;
        end
    end

    // an idle parser only wakes up on a start-of-string character
    a_idle_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE && !(step_fire && r_sos)) |=> r_phase == PH_IDLE)
        else $error("parser left idle without a start of string");

    a_emit_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && step_ctl.emit) |=> (r_phase == PH_IDLE && r_out_valid))
        else $error("result issued but parser not idle or result lost");

    a_zero_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_SIGN || r_status == ST_PREFIX)) |-> r_value == '0)
        else $error("sign or prefix reject with nonzero value");

    a_base_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_BAD_BASE) |-> r_value[OUT_W-1:RADIX_W] == '0)
        else $error("invalid base result wider than a radix");

endmodule
